@@ design/top_three_spectral_peaks_macros.svh @@
// ----------------------------------------------------------------------------
// Top three spectral peaks: assertion macros
// Shared helpers for the concurrent checks in the design files.
// ----------------------------------------------------------------------------
`ifndef TOP_THREE_SPECTRAL_PEAKS_MACROS_SVH
`define TOP_THREE_SPECTRAL_PEAKS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tstp_pkg.sv @@
// ----------------------------------------------------------------------------
// Top three spectral peaks: package
// Word types, field widths, register map and reset values.
// ----------------------------------------------------------------------------
package tstp_pkg;

  localparam int IDX_W   = 10;
  localparam int LEVEL_W = 32;
  localparam int BW_W    = 24;
  localparam int FREQ_W  = IDX_W + BW_W;
  localparam int NUM_BINS = 1024;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-3:0] REG_FIRST_BIN = 1'd0;
  localparam logic [ADDR_W-3:0] REG_BIN_WIDTH = 1'd1;

  localparam logic [IDX_W-1:0] FIRST_BIN_RST = 10'd2;
  localparam logic [BW_W-1:0]  BIN_WIDTH_RST = 24'd32000;

  typedef struct packed {
    logic [LEVEL_W-1:0] magnitude;
    logic               last_bin;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   first_index;
    logic [LEVEL_W-1:0] first_level;
    logic [FREQ_W-1:0]  first_freq;
    logic [IDX_W-1:0]   second_index;
    logic [LEVEL_W-1:0] second_level;
    logic [FREQ_W-1:0]  second_freq;
    logic [IDX_W-1:0]   third_index;
    logic [LEVEL_W-1:0] third_level;
    logic [FREQ_W-1:0]  third_freq;
  } out_word_t;

  typedef struct packed {
    logic [2:0][IDX_W-1:0]   idx;
    logic [2:0][LEVEL_W-1:0] level;
  } peaks_t;

endpackage

@@ design/tstp_rank.sv @@
// ----------------------------------------------------------------------------
// Top three spectral peaks: ranking stage
// Counts bins and keeps the running top three of the current frame.
// ----------------------------------------------------------------------------
`include "top_three_spectral_peaks_macros.svh"

module tstp_rank #(
  parameter int MAG_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  tstp_pkg::in_word_t       in_word,
  input  logic [tstp_pkg::IDX_W-1:0] first_bin,
  output tstp_pkg::peaks_t         peaks
);
  import tstp_pkg::*;

  logic [IDX_W-1:0]             cnt_r, cnt_nxt;
  logic [2:0][IDX_W-1:0]        idx_r, idx_nxt;
  logic [2:0][MAG_BITS-1:0]     lvl_r, lvl_nxt;
  logic [MAG_BITS-1:0]          mag;
  logic                         take;

  assign mag     = in_word.magnitude[MAG_BITS-1:0];
  assign take    = (cnt_r >= first_bin) && (32'(cnt_r) < NUM_BINS);
  assign cnt_nxt = cnt_r + 1'b1;

  always_comb begin
    idx_nxt = idx_r;
    lvl_nxt = lvl_r;
    priority if (take && (mag > lvl_r[0])) begin
      idx_nxt[2] = idx_r[1];
      lvl_nxt[2] = lvl_r[1];
      idx_nxt[1] = idx_r[0];
      lvl_nxt[1] = lvl_r[0];
      idx_nxt[0] = cnt_r;
      lvl_nxt[0] = mag;
    end else if (take && (mag > lvl_r[1])) begin
      idx_nxt[2] = idx_r[1];
      lvl_nxt[2] = lvl_r[1];
      idx_nxt[1] = cnt_r;
      lvl_nxt[1] = mag;
    end else if (take && (mag > lvl_r[2])) begin
      idx_nxt[2] = cnt_r;
      lvl_nxt[2] = mag;
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      peaks.idx[k]   = idx_nxt[k];
      peaks.level[k] = LEVEL_W'(lvl_nxt[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      lvl_r <= '0;
    end else if (accept) begin
      if (in_word.last_bin) begin
        cnt_r <= '0;
        idx_r <= '0;
        lvl_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        idx_r <= idx_nxt;
        lvl_r <= lvl_nxt;
      end
    end
  end

  `TSTP_ASSERT_NEXT(a_frame_clears, clk, rst_n, accept && in_word.last_bin, (cnt_r == '0) && (lvl_r[0] == '0), "Ranking did not clear after the last bin.")
  `TSTP_ASSERT_NOW(a_ranks_ordered, clk, rst_n, 1'b1, (lvl_r[0] >= lvl_r[1]) && (lvl_r[1] >= lvl_r[2]), "Ranked levels are out of order.")
  `TSTP_ASSERT_NEXT(a_count_steps, clk, rst_n, accept && !in_word.last_bin, cnt_r == $past(cnt_nxt), "Bin counter did not advance.")

endmodule

@@ design/top_three_spectral_peaks.sv @@
// ----------------------------------------------------------------------------
// Top three spectral peaks: top level
// Ranks a stream of magnitude bins and reports the three largest per frame.
// ----------------------------------------------------------------------------
// The input channel carries one magnitude bin per word, with last_bin marking
// the final bin of a frame. The block numbers bins itself from zero, ranks
// bins at or above first_bin, and on the last bin emits one output word with
// the three indices, levels and frequencies (index times bin_width).
// A new input word is accepted every cycle unless in_stall is high; the
// ranking compare and shift is a single registered step. When the last bin
// is accepted, the capture register takes the final ranking; the output
// register then takes its three 10 by 24 bit frequency products.
// If the receiver stalls, the output word holds, one further result waits in
// the capture register, and in_stall rises only when both are full.
// Reset clears the bin counter, the ranking and both result stages, and sets
// first_bin to 2 and bin_width to 32000. The APB port writes and reads the
// two registers at byte addresses 0 and 4; write them only while idle.
// ----------------------------------------------------------------------------
`include "top_three_spectral_peaks_macros.svh"

module top_three_spectral_peaks #(
  parameter int MAG_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  tstp_pkg::in_word_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output tstp_pkg::out_word_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tstp_pkg::ADDR_W-1:0]    paddr,
  input  logic [tstp_pkg::DATA_W-1:0]    pwdata,
  output logic [tstp_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import tstp_pkg::*;

  logic [IDX_W-1:0]   first_bin_r;
  logic [BW_W-1:0]    bin_width_r;
  logic               cfg_write;
  logic               in_accept;
  logic               out_load;
  logic               s1_valid_r, s1_valid_nxt;
  peaks_t             s1_peaks_r;
  peaks_t             peaks_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;
  logic [2:0][FREQ_W-1:0] freq;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_bin_r <= FIRST_BIN_RST;
      bin_width_r <= BIN_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (paddr[ADDR_W-1:2])
        REG_FIRST_BIN: first_bin_r <= pwdata[IDX_W-1:0];
        REG_BIN_WIDTH: bin_width_r <= pwdata[BW_W-1:0];
        default:       first_bin_r <= first_bin_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_FIRST_BIN: prdata = DATA_W'(first_bin_r);
      REG_BIN_WIDTH: prdata = DATA_W'(bin_width_r);
      default:       prdata = '0;
    endcase
  end

  assign out_load  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  tstp_rank #(
    .MAG_BITS (MAG_BITS)
  ) u_rank (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .in_word   (in_data),
    .first_bin (first_bin_r),
    .peaks     (peaks_nxt)
  );

  always_comb begin
    priority if (in_accept && in_data.last_bin) begin
      s1_valid_nxt = 1'b1;
    end else if (out_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      freq[k] = FREQ_W'(s1_peaks_r.idx[k]) * FREQ_W'(bin_width_r);
    end
    out_data_nxt.first_index  = s1_peaks_r.idx[0];
    out_data_nxt.first_level  = s1_peaks_r.level[0];
    out_data_nxt.first_freq   = freq[0];
    out_data_nxt.second_index = s1_peaks_r.idx[1];
    out_data_nxt.second_level = s1_peaks_r.level[1];
    out_data_nxt.second_freq  = freq[1];
    out_data_nxt.third_index  = s1_peaks_r.idx[2];
    out_data_nxt.third_level  = s1_peaks_r.level[2];
    out_data_nxt.third_freq   = freq[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_bin) begin
      s1_peaks_r <= peaks_nxt;
    end
    if (out_load && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSTP_ASSERT_NOW(a_stall_when_full, clk, rst_n, in_stall, s1_valid_r && out_valid_r, "Input stalled while a result stage was free.")
  `TSTP_ASSERT_NEXT(a_last_captured, clk, rst_n, in_accept && in_data.last_bin, s1_valid_r, "Last bin did not capture a result.")
  `TSTP_ASSERT_NEXT(a_result_moves, clk, rst_n, s1_valid_r && out_load, out_valid_r, "Captured result did not reach the output.")

endmodule
